// ----- rtl/sorted_sequence_table_defines.svh -----
// Assertion macros for the sorted sequence table
`ifndef SORTED_SEQUENCE_TABLE_DEFINES_SVH
`define SORTED_SEQUENCE_TABLE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SST_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("sst check failed");
`define SST_ASSERT_NXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("sst check failed");
`else
`define SST_ASSERT_IMP(label, clk, rst_n, pre, post)
`define SST_ASSERT_NXT(label, clk, rst_n, pre, post)
`endif
`endif

// ----- rtl/sst_pkg.sv -----
package sst_pkg;
  localparam int unsigned TableDepth = 64;
  localparam int unsigned HandleBits = 8;
  localparam int unsigned IdxW = $clog2(TableDepth);
  localparam int unsigned CntW = $clog2(TableDepth + 1);

  localparam logic [1:0] FUNC_INSERT  = 2'd0;
  localparam logic [1:0] FUNC_REMOVE  = 2'd1;
  localparam logic [1:0] FUNC_FIND    = 2'd2;
  localparam logic [1:0] FUNC_HIGHEST = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_MISS  = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef struct packed {
    logic [31:0]         seq;
    logic [19:0]         inst;
    logic [HandleBits-1:0] hnd;
  } entry_t;

  // memory port bundle from the sequencer to the table RAM
  typedef struct packed {
    logic            rd_en;
    logic [IdxW-1:0] rd_addr;
    logic            wr_en;
    logic [IdxW-1:0] wr_addr;
    entry_t          wr_data;
  } mem_req_t;
endpackage

// ----- rtl/sst_ram.sv -----
module sst_ram (
  input  logic              clk,
  input  sst_pkg::mem_req_t req,
  output sst_pkg::entry_t   rd_data
);
  sst_pkg::entry_t mem [sst_pkg::TableDepth];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end
endmodule

// ----- rtl/sst_seq.sv -----
`include "sorted_sequence_table_defines.svh"
module sst_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [1:0]        func,
  input  logic [31:0]       seq_key,
  input  logic [19:0]       inst_key,
  input  logic              any_inst,
  input  logic [7:0]        hnd_key,
  output logic              busy,
  output logic              done,
  output logic [1:0]        res_status,
  output logic [7:0]        res_handle,
  output logic [31:0]       res_seq,
  output logic [6:0]        res_total,
  output sst_pkg::mem_req_t req,
  input  sst_pkg::entry_t   rd_data
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INS  = 3'd1; // shift up while above key
  localparam logic [2:0] S_RSRC = 3'd2; // search handle
  localparam logic [2:0] S_RSH  = 3'd3; // shift down
  localparam logic [2:0] S_FIND = 3'd4;
  localparam logic [2:0] S_TOP  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;
  localparam int unsigned IdxW = sst_pkg::IdxW;
  localparam int unsigned CntW = sst_pkg::CntW;

  logic [2:0] state_r, state_nxt;
  logic [CntW-1:0] fill_r, fill_nxt;
  logic [CntW-1:0] ptr_r, ptr_nxt;      // position being read (read issued for ptr-1, ptr or ptr+1)
  logic [31:0] key_r;
  logic [19:0] inst_r;
  logic        any_r;
  logic [sst_pkg::HandleBits-1:0] hnd_r;
  logic        hv_r, hv_nxt;
  sst_pkg::entry_t hit_r, hit_nxt;
  sst_pkg::entry_t rem_r, rem_nxt;
  logic [1:0]  st_r, st_nxt;
  logic [7:0]  ho_r, ho_nxt;
  logic [31:0] so_r, so_nxt;
  sst_pkg::mem_req_t req_c;
  sst_pkg::entry_t new_e;
  logic inst_ok;

  assign new_e.seq  = key_r;
  assign new_e.inst = inst_r;
  assign new_e.hnd  = hnd_r;
  assign inst_ok = any_r || (rd_data.inst == inst_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
      hv_r    <= 1'b0;
      hit_r   <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      hv_r    <= hv_nxt;
      hit_r   <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r   <= ptr_nxt;
    rem_r   <= rem_nxt;
    st_r    <= st_nxt;
    ho_r    <= ho_nxt;
    so_r    <= so_nxt;
    if (start) begin
      key_r  <= seq_key;
      inst_r <= inst_key;
      any_r  <= any_inst;
      hnd_r  <= hnd_key[sst_pkg::HandleBits-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    ptr_nxt   = ptr_r;
    hv_nxt    = hv_r;
    hit_nxt   = hit_r;
    rem_nxt   = rem_r;
    st_nxt    = st_r;
    ho_nxt    = ho_r;
    so_nxt    = so_r;
    req_c     = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          st_nxt = sst_pkg::ST_OK;
          ho_nxt = '0;
          so_nxt = '0;
          ptr_nxt = fill_r;
          if (func == sst_pkg::FUNC_INSERT) begin
            if (fill_r == CntW'(sst_pkg::TableDepth)) begin
              st_nxt = sst_pkg::ST_FULL;
              state_nxt = S_DONE;
            end else if (fill_r == '0) begin
              state_nxt = S_INS;
            end else begin
              req_c.rd_en = 1'b1;
              req_c.rd_addr = IdxW'(fill_r - 1'b1);
              state_nxt = S_INS;
            end
          end else if (fill_r == '0) begin
            st_nxt = sst_pkg::ST_EMPTY;
            state_nxt = S_DONE;
          end else if (func == sst_pkg::FUNC_REMOVE) begin
            ptr_nxt = '0;
            req_c.rd_en = 1'b1;
            req_c.rd_addr = '0;
            state_nxt = S_RSRC;
          end else if (func == sst_pkg::FUNC_FIND) begin
            if (hv_r && hit_r.seq == seq_key && (any_inst || hit_r.inst == inst_key)) begin
              ho_nxt = 8'(hit_r.hnd);
              so_nxt = hit_r.seq;
              state_nxt = S_DONE;
            end else begin
              req_c.rd_en = 1'b1;
              req_c.rd_addr = IdxW'(fill_r - 1'b1);
              state_nxt = S_FIND;
            end
          end else begin
            req_c.rd_en = 1'b1;
            req_c.rd_addr = IdxW'(fill_r - 1'b1);
            state_nxt = S_TOP;
          end
        end
      end
      // rd_data holds entry ptr-1; move it up to ptr while above the key
      S_INS: begin
        if (ptr_r != '0 && rd_data.seq > key_r) begin
          req_c.wr_en = 1'b1;
          req_c.wr_addr = IdxW'(ptr_r);
          req_c.wr_data = rd_data;
          ptr_nxt = ptr_r - 1'b1;
          if (ptr_r != CntW'(1)) begin
            req_c.rd_en = 1'b1;
            req_c.rd_addr = IdxW'(ptr_r - 2'd2);
          end
        end else begin
          req_c.wr_en = 1'b1;
          req_c.wr_addr = IdxW'(ptr_r);
          req_c.wr_data = new_e;
          fill_nxt = fill_r + 1'b1;
          state_nxt = S_DONE;
        end
      end
      // rd_data holds entry ptr
      S_RSRC: begin
        if (rd_data.hnd == hnd_r) begin
          rem_nxt = rd_data;
          ho_nxt = 8'(rd_data.hnd);
          so_nxt = rd_data.seq;
          if (ptr_r + 1'b1 < fill_r) begin
            req_c.rd_en = 1'b1;
            req_c.rd_addr = IdxW'(ptr_r + 1'b1);
            state_nxt = S_RSH;
          end else begin
            fill_nxt = fill_r - 1'b1;
            if (hv_r && hit_r == rd_data) hv_nxt = 1'b0;
            state_nxt = S_DONE;
          end
        end else if (ptr_r + 1'b1 < fill_r) begin
          ptr_nxt = ptr_r + 1'b1;
          req_c.rd_en = 1'b1;
          req_c.rd_addr = IdxW'(ptr_r + 1'b1);
        end else begin
          st_nxt = sst_pkg::ST_MISS;
          state_nxt = S_DONE;
        end
      end
      // rd_data holds entry ptr+1; copy it down to ptr
      S_RSH: begin
        req_c.wr_en = 1'b1;
        req_c.wr_addr = IdxW'(ptr_r);
        req_c.wr_data = rd_data;
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r + 2'd2 < fill_r) begin
          req_c.rd_en = 1'b1;
          req_c.rd_addr = IdxW'(ptr_r + 2'd2);
        end else begin
          fill_nxt = fill_r - 1'b1;
          if (hv_r && hit_r == rem_r) hv_nxt = 1'b0;
          state_nxt = S_DONE;
        end
      end
      // rd_data holds entry ptr-1
      S_FIND: begin
        if (rd_data.seq == key_r && inst_ok) begin
          hv_nxt = 1'b1;
          hit_nxt = rd_data;
          ho_nxt = 8'(rd_data.hnd);
          so_nxt = rd_data.seq;
          state_nxt = S_DONE;
        end else if (rd_data.seq < key_r || ptr_r == CntW'(1)) begin
          st_nxt = sst_pkg::ST_MISS;
          state_nxt = S_DONE;
        end else begin
          ptr_nxt = ptr_r - 1'b1;
          req_c.rd_en = 1'b1;
          req_c.rd_addr = IdxW'(ptr_r - 2'd2);
        end
      end
      S_TOP: begin
        ho_nxt = 8'(rd_data.hnd);
        so_nxt = rd_data.seq;
        state_nxt = S_DONE;
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign req        = req_c;
  assign busy       = (state_r != S_IDLE);
  assign done       = (state_r == S_DONE);
  assign res_status = st_r;
  assign res_handle = ho_r;
  assign res_seq    = so_r;
  assign res_total  = 7'(fill_r);

  `SST_ASSERT_IMP(a_fill_max, clk, rst_n, 1'b1, fill_r <= CntW'(sst_pkg::TableDepth))
  `SST_ASSERT_IMP(a_wr_busy, clk, rst_n, req_c.wr_en, state_r != S_IDLE)
  `SST_ASSERT_NXT(a_ins_grow, clk, rst_n,
    state_r == S_INS && state_nxt == S_DONE, fill_r == $past(fill_r) + 1'b1)
  `SST_ASSERT_NXT(a_full_hold, clk, rst_n,
    state_r == S_IDLE && start && func == sst_pkg::FUNC_INSERT &&
    fill_r == CntW'(sst_pkg::TableDepth), st_r == sst_pkg::ST_FULL)
endmodule

// ----- rtl/sorted_sequence_table.sv -----
// Channel | Dir | Fields (tdata from bit 0)
// in_     | in  | seq_key[31:0] instance_key[51:32] any_instance[52] handle_in[60:53]; tuser=func
// out_    | out | handle_out[7:0] seq_out[39:8] entry_total[46:40]; tuser=status
// One item at a time: insert, remove and find walk the RAM one entry a cycle, since the
// RAM has one read port: insert shifts entries up and then makes the final write, remove
// searches and shifts down, the two together crossing the table once, find scans the
// table, and highest reads the top entry only.
// Reset clears the fill count and the hit cache; the table RAM needs no clearing.
// The result waits in an output register; a stalled output holds the next item off.
module sorted_sequence_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,  // seq_key, instance_key, any_instance, handle_in, zero pad
  input  logic [1:0]  in_tuser,  // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata, // handle_out, seq_out, entry_total, zero pad
  output logic [1:0]  out_tuser  // status
);
  logic busy, done, start;
  logic [1:0]  res_status;
  logic [7:0]  res_handle;
  logic [31:0] res_seq;
  logic [6:0]  res_total;
  logic        ov_r;
  sst_pkg::mem_req_t req;
  sst_pkg::entry_t   rd_data;

  // take an item only when the sequencer is free and no result waits
  assign in_tready = !busy && !ov_r;
  assign start     = in_tvalid && in_tready;

  sst_seq u_seq (
    .clk, .rst_n, .start,
    .func(in_tuser), .seq_key(in_tdata[31:0]), .inst_key(in_tdata[51:32]),
    .any_inst(in_tdata[52]), .hnd_key(in_tdata[60:53]),
    .busy, .done, .res_status, .res_handle, .res_seq, .res_total,
    .req, .rd_data
  );

  sst_ram u_ram (.clk, .req, .rd_data);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (done) begin
      ov_r <= 1'b1;
    end else if (out_tready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_tdata <= {1'b0, res_total, res_seq, res_handle};
      out_tuser <= res_status;
    end
  end

  assign out_tvalid = ov_r;
endmodule

// ----- sim/tb_sorted_sequence_table.sv -----
module tb_sorted_sequence_table;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH = sst_pkg::TableDepth;

  typedef struct {
    logic [1:0]  func;
    logic [31:0] seq_key;
    logic [19:0] instance_key;
    logic        any_instance;
    logic [7:0]  handle_in;
  } request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  handle_out;
    logic [31:0] seq_out;
    logic [6:0]  entry_total;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic [1:0]  out_tuser;

  sorted_sequence_table dut (.*);

  always #6 clk = ~clk;

  // Shadow copy of the table, kept in step with accepted requests
  logic [31:0] tbl_seq [DEPTH];
  logic [19:0] tbl_inst [DEPTH];
  logic [7:0]  tbl_hnd [DEPTH];
  int unsigned tbl_fill = 0;
  logic        cache_ok = 1'b0;
  logic [31:0] cache_seq = '0;
  logic [19:0] cache_inst = '0;
  logic [7:0]  cache_hnd = '0;

  request_t pending_reqs[$];
  reply_t   expected_replies[$];
  int unsigned mismatches = 0;
  int unsigned replies_seen = 0;
  int unsigned hits_seen = 0;
  int unsigned fulls_seen = 0;
  int unsigned sent_n = 0;
  int unsigned taken_n = 0;
  int unsigned hold_cycles = 0;
  bit          hold_request = 1'b0;
  bit          sender_quiet = 1'b0;
  bit          receiver_quiet = 1'b0;

  function automatic reply_t apply_request(request_t r);
    reply_t      y;
    int unsigned i;
    int unsigned k;
    logic [31:0] rs;
    logic [19:0] ri;
    logic [7:0]  rh;
    y = '{sst_pkg::ST_OK, 8'd0, 32'd0, 7'd0};
    if (r.func == sst_pkg::FUNC_INSERT) begin
      if (tbl_fill >= DEPTH) begin
        y.status = sst_pkg::ST_FULL;
      end else begin
        i = tbl_fill;
        while (i > 0 && tbl_seq[i-1] > r.seq_key) begin
          tbl_seq[i] = tbl_seq[i-1];
          tbl_inst[i] = tbl_inst[i-1];
          tbl_hnd[i] = tbl_hnd[i-1];
          i--;
        end
        tbl_seq[i] = r.seq_key;
        tbl_inst[i] = r.instance_key;
        tbl_hnd[i] = r.handle_in;
        tbl_fill++;
      end
    end else if (tbl_fill == 0) begin
      y.status = sst_pkg::ST_EMPTY;
    end else if (r.func == sst_pkg::FUNC_REMOVE) begin
      i = 0;
      while (i < tbl_fill && tbl_hnd[i] != r.handle_in) i++;
      if (i >= tbl_fill) begin
        y.status = sst_pkg::ST_MISS;
      end else begin
        rs = tbl_seq[i];
        ri = tbl_inst[i];
        rh = tbl_hnd[i];
        for (k = i; k + 1 < tbl_fill; k++) begin
          tbl_seq[k] = tbl_seq[k+1];
          tbl_inst[k] = tbl_inst[k+1];
          tbl_hnd[k] = tbl_hnd[k+1];
        end
        tbl_fill--;
        // drop the cache if it named the removed entry
        if (cache_ok && cache_seq == rs && cache_inst == ri && cache_hnd == rh)
          cache_ok = 1'b0;
        y.handle_out = rh;
        y.seq_out = rs;
      end
    end else if (r.func == sst_pkg::FUNC_FIND) begin
      if (cache_ok && cache_seq == r.seq_key &&
          (r.any_instance || cache_inst == r.instance_key)) begin
        y.handle_out = cache_hnd;
        y.seq_out = cache_seq;
      end else begin
        y.status = sst_pkg::ST_MISS;
        i = tbl_fill;
        while (i > 0) begin
          if (tbl_seq[i-1] == r.seq_key &&
              (r.any_instance || tbl_inst[i-1] == r.instance_key)) begin
            cache_ok = 1'b1;
            cache_seq = tbl_seq[i-1];
            cache_inst = tbl_inst[i-1];
            cache_hnd = tbl_hnd[i-1];
            y = '{sst_pkg::ST_OK, cache_hnd, cache_seq, 7'd0};
            break;
          end
          if (tbl_seq[i-1] < r.seq_key) break;
          i--;
        end
      end
    end else begin
      y.handle_out = tbl_hnd[tbl_fill-1];
      y.seq_out = tbl_seq[tbl_fill-1];
    end
    y.entry_total = 7'(tbl_fill);
    return y;
  endfunction

  function automatic request_t make_req(logic [1:0] f, logic [31:0] s, int unsigned n,
                                        int unsigned a, int unsigned h);
    request_t r;
    r = '{f, s, 20'(n), 1'(a), 8'(h)};
    return r;
  endfunction

  // Accept on the rising edge: drop the item from the queue and predict its reply
  always @(posedge clk) begin
    request_t r;
    if (rst_n && in_tvalid && in_tready) begin
      r = pending_reqs.pop_front();
      expected_replies.push_back(apply_request(r));
      taken_n++;
    end
  end

  // Sender: at the falling edge hold an offered item until taken, else offer the next
  always @(negedge clk) begin
    request_t r;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && taken_n != sent_n) begin
      in_tvalid <= 1'b1;
    end else if (pending_reqs.size() == 0 ||
                 (!sender_quiet && $urandom_range(99) < 37)) begin
      in_tvalid <= 1'b0;
    end else begin
      r = pending_reqs[0];
      sent_n++;
      in_tvalid <= 1'b1;
      in_tuser <= r.func;
      in_tdata <= {3'b0, r.handle_in, r.any_instance, r.instance_key, r.seq_key};
    end
  end

  // Receiver readiness, changed at the falling edge; a long hold is counted here
  always @(negedge clk) begin
    if (hold_cycles != 0) begin
      hold_cycles--;
    end else if (hold_request) begin
      hold_cycles = 400;
    end
    out_tready <= rst_n && hold_cycles == 0 && (receiver_quiet || $urandom_range(99) >= 37);
  end

  // Check each reply against the oldest prediction
  always @(posedge clk) begin
    reply_t want;
    reply_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tuser, out_tdata[7:0], out_tdata[39:8], out_tdata[46:40]};
      replies_seen++;
      if (expected_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected reply status=%0d", got.status);
      end else begin
        want = expected_replies.pop_front();
        if (got.status == sst_pkg::ST_OK && want.status == sst_pkg::ST_OK &&
            want.handle_out != 0)
          hits_seen++;
        if (got.status == sst_pkg::ST_FULL) fulls_seen++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st=%0d h=%0h s=%0h n=%0d, got st=%0d h=%0h s=%0h n=%0d",
                     want.status, want.handle_out, want.seq_out, want.entry_total,
                     got.status, got.handle_out, got.seq_out, got.entry_total);
        end
      end
    end
  end

  // Stimulus shadow: track which handles and keys sit in the table
  logic [31:0] live_seq[$];
  logic [19:0] live_inst[$];
  logic [7:0]  live_hnd[$];

  function automatic request_t random_req();
    request_t    r;
    int unsigned p;
    int unsigned pick;
    int unsigned kind;
    kind = $urandom_range(99);
    r = make_req(sst_pkg::FUNC_INSERT, $urandom, $urandom, $urandom_range(1), $urandom);
    // keep keys clustered so duplicates and early scan exits happen
    if ($urandom_range(3) != 0) r.seq_key = $urandom_range(40);
    if ($urandom_range(3) != 0) r.instance_key = 20'($urandom_range(3));
    if ($urandom_range(3) != 0) r.handle_in = 8'($urandom_range(31));
    if (kind < 35) begin
      r.func = sst_pkg::FUNC_INSERT;
    end else if (kind < 60) begin
      r.func = sst_pkg::FUNC_REMOVE;
    end else if (kind < 92) begin
      r.func = sst_pkg::FUNC_FIND;
    end else begin
      r.func = sst_pkg::FUNC_HIGHEST;
    end
    p = live_seq.size();
    if (p > 0 && $urandom_range(3) != 0) begin
      pick = $urandom_range(p - 1);
      r.seq_key = live_seq[pick];
      if ($urandom_range(2) != 0) r.instance_key = live_inst[pick];
      if (r.func == sst_pkg::FUNC_REMOVE) r.handle_in = live_hnd[pick];
    end
    // approximate stimulus-side bookkeeping for aiming keys
    if (r.func == sst_pkg::FUNC_INSERT && p < DEPTH) begin
      live_seq.push_back(r.seq_key);
      live_inst.push_back(r.instance_key);
      live_hnd.push_back(r.handle_in);
    end else if (r.func == sst_pkg::FUNC_REMOVE) begin
      foreach (live_hnd[j]) begin
        if (live_hnd[j] == r.handle_in) begin
          live_seq.delete(j);
          live_inst.delete(j);
          live_hnd.delete(j);
          break;
        end
      end
    end
    return r;
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || expected_replies.size() != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned n;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty-table queries, extremes, duplicates, cache removal
    pending_reqs.push_back(make_req(sst_pkg::FUNC_REMOVE, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(sst_pkg::FUNC_FIND, 0, 0, 1, 0));
    pending_reqs.push_back(make_req(sst_pkg::FUNC_HIGHEST, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(sst_pkg::FUNC_INSERT, 32'hFFFF_FFFF, 20'hFFFFF, 1, 8'hFF));
    pending_reqs.push_back(make_req(sst_pkg::FUNC_INSERT, 0, 0, 0, 8'h00));
    pending_reqs.push_back(make_req(sst_pkg::FUNC_INSERT, 7, 5, 0, 8'h11));
    pending_reqs.push_back(make_req(sst_pkg::FUNC_INSERT, 7, 6, 0, 8'h11));
    pending_reqs.push_back(make_req(sst_pkg::FUNC_HIGHEST, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(sst_pkg::FUNC_FIND, 7, 5, 0, 0));
    pending_reqs.push_back(make_req(sst_pkg::FUNC_FIND, 7, 5, 0, 0));
    pending_reqs.push_back(make_req(sst_pkg::FUNC_FIND, 7, 9, 1, 0));
    pending_reqs.push_back(make_req(sst_pkg::FUNC_FIND, 7, 9, 0, 0));
    pending_reqs.push_back(make_req(sst_pkg::FUNC_FIND, 3, 0, 1, 0));
    pending_reqs.push_back(make_req(sst_pkg::FUNC_REMOVE, 0, 0, 0, 8'h11));
    pending_reqs.push_back(make_req(sst_pkg::FUNC_FIND, 7, 6, 1, 0));
    pending_reqs.push_back(make_req(sst_pkg::FUNC_REMOVE, 0, 0, 0, 8'h11));
    pending_reqs.push_back(make_req(sst_pkg::FUNC_FIND, 7, 6, 1, 0));
    pending_reqs.push_back(make_req(sst_pkg::FUNC_REMOVE, 0, 0, 0, 8'h42));
    pending_reqs.push_back(make_req(sst_pkg::FUNC_REMOVE, 0, 0, 0, 8'hFF));
    pending_reqs.push_back(make_req(sst_pkg::FUNC_REMOVE, 0, 0, 0, 8'h00));
    wait_drained();

    // Fill past the top, with the receiver held off so the block backs up
    hold_request = 1'b1;
    wait (hold_cycles != 0);
    hold_request = 1'b0;
    for (int i = 0; i < DEPTH + 2; i++)
      pending_reqs.push_back(make_req(sst_pkg::FUNC_INSERT, $urandom, $urandom, 0, $urandom));
    wait (hold_cycles == 0);
    pending_reqs.push_back(make_req(sst_pkg::FUNC_HIGHEST, 0, 0, 0, 0));
    for (int i = 0; i < DEPTH + 1; i++)
      pending_reqs.push_back(make_req(sst_pkg::FUNC_REMOVE, 0, 0, 0, tbl_hnd[0]));
    wait_drained();
    // the removes above name a stale handle at queue time; drain whatever is left
    while (tbl_fill > 0) begin
      pending_reqs.push_back(make_req(sst_pkg::FUNC_REMOVE, 0, 0, 0, tbl_hnd[0]));
      wait_drained();
    end
    live_seq.delete();
    live_inst.delete();
    live_hnd.delete();

    // Random phase with a quiet stretch and a sender pause
    n = 0;
    while (n < 1850) begin
      if (n == 600) begin
        sender_quiet = 1'b1;
        receiver_quiet = 1'b1;
      end
      if (n == 800) begin
        sender_quiet = 1'b0;
        receiver_quiet = 1'b0;
        // hold new items back until every reply is in
        wait_drained();
      end
      pending_reqs.push_back(random_req());
      n++;
      if (pending_reqs.size() > 8) @(posedge clk);
    end
    wait_drained();
    repeat (2 * DEPTH + 10) @(posedge clk);
    $display("Ran directed and %0d random operations: %0d replies, %0d hits, %0d full.",
             n, replies_seen, hits_seen, fulls_seen);
    if (mismatches == 0 && expected_replies.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("Timeout with %0d replies outstanding", expected_replies.size());
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
